FILE: rtl/adavg_pkg.sv
// Shared types and constants for the decimating accelerometer averager.
// Used by every module in rtl; depends on nothing else.
`timescale 1ns / 1ps

package adavg_pkg;

   localparam int SUM_WIDTH = 32;
   localparam int RAW_WIDTH = 16;
   localparam int VAL_WIDTH = 12;
   localparam int AVG_WIDTH = 16;
   localparam int CAP_WIDTH = 8;
   localparam int COUNT_WIDTH = 16;
   localparam int DIV_STEPS = SUM_WIDTH;
   localparam int STEP_WIDTH = $clog2(DIV_STEPS);
   localparam int LANES = 3;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 8'd32;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 16'hFFFF;
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   // One request as it sits in the front queue, already classified and unpacked.
   typedef struct packed {
      logic is_tick;
      logic [VAL_WIDTH-1:0] val_x;
      logic [VAL_WIDTH-1:0] val_y;
      logic [VAL_WIDTH-1:0] val_z;
      logic pin;
   } item_type;

   typedef struct packed {
      logic start;
      logic [CAP_WIDTH-1:0] divisor;
   } div_ctrl_type;

   // The 12-bit value sits in bits 15:4 of the raw word.
   function automatic logic [VAL_WIDTH-1:0] extract12(input logic [RAW_WIDTH-1:0] word);
      return word[RAW_WIDTH-1:RAW_WIDTH-VAL_WIDTH];
   endfunction

   function automatic logic [SUM_WIDTH-1:0] widen12(input logic [VAL_WIDTH-1:0] val);
      return {{(SUM_WIDTH-VAL_WIDTH){val[VAL_WIDTH-1]}}, val};
   endfunction

endpackage

FILE: rtl/accel_decimating_averager.sv
// Sample requests are absorbed one per cycle while the back end is idle; none is taken
// while a tick is in flight. An accepted tick request starts the divider, runs the
// bit-serial divider (one quotient bit per cycle), sees done and then puts its result
// on the ports by loading the result register once free. Ticks finish one at a time;
// a two-entry request queue and the result register let each side stall on its own.
// Synchronous active-high reset clears sums, count, watchdog and queues; cap goes to 32.
`timescale 1ns / 1ps

module accel_decimating_averager (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic req_command,
   input  logic [15:0] req_raw_x,
   input  logic [15:0] req_raw_y,
   input  logic [15:0] req_raw_z,
   input  logic req_pin_high,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic signed [15:0] rsp_avg_x,
   output logic signed [15:0] rsp_avg_y,
   output logic signed [15:0] rsp_avg_z,
   output logic [7:0] rsp_used_count,
   output logic rsp_retrigger,
   input  logic csr_write_en,
   input  logic [7:0] csr_write_data
);

   logic [adavg_pkg::CAP_WIDTH-1:0] cap_ff, cap_in;
   logic head_valid;
   logic head_take;
   adavg_pkg::item_type head_item;

   assign cap_in = csr_write_en ? csr_write_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= adavg_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   adavg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_command  (req_command),
      .req_raw_x    (req_raw_x),
      .req_raw_y    (req_raw_y),
      .req_raw_z    (req_raw_z),
      .req_pin_high (req_pin_high),
      .head_valid   (head_valid),
      .head_item    (head_item),
      .head_take    (head_take)
   );

   adavg_back u_back (
      .clock          (clock),
      .reset          (reset),
      .divisor_cap    (cap_ff),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .head_take      (head_take),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_avg_x      (rsp_avg_x),
      .rsp_avg_y      (rsp_avg_y),
      .rsp_avg_z      (rsp_avg_z),
      .rsp_used_count (rsp_used_count),
      .rsp_retrigger  (rsp_retrigger)
   );

endmodule

FILE: rtl/adavg_front.sv
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on adavg_pkg.
`timescale 1ns / 1ps

module adavg_front (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic req_command,
   input  logic [adavg_pkg::RAW_WIDTH-1:0] req_raw_x,
   input  logic [adavg_pkg::RAW_WIDTH-1:0] req_raw_y,
   input  logic [adavg_pkg::RAW_WIDTH-1:0] req_raw_z,
   input  logic req_pin_high,
   output logic head_valid,
   output adavg_pkg::item_type head_item,
   input  logic head_take
);

   adavg_pkg::item_type entry_ff [2];
   adavg_pkg::item_type new_item;
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push_ok;
   logic pop_ok;

   assign req_full = (count_ff == 2'd2);
   assign push_ok = req_push && !req_full;
   assign head_valid = (count_ff != 2'd0);
   assign pop_ok = head_take && head_valid;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      new_item.is_tick = (req_command == adavg_pkg::CMD_TICK);
      new_item.val_x = adavg_pkg::extract12(req_raw_x);
      new_item.val_y = adavg_pkg::extract12(req_raw_y);
      new_item.val_z = adavg_pkg::extract12(req_raw_z);
      new_item.pin = req_pin_high;
   end

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: rtl/adavg_divider.sv
// Bit-serial restoring divider: three 32-bit magnitudes by one 8-bit divisor,
// one quotient bit per cycle in each lane. Depends on adavg_pkg.
`timescale 1ns / 1ps

module adavg_divider (
   input  logic clock,
   input  logic reset,
   input  adavg_pkg::div_ctrl_type ctrl,
   input  logic [adavg_pkg::LANES-1:0][adavg_pkg::SUM_WIDTH-1:0] mag,
   input  logic [adavg_pkg::LANES-1:0] neg,
   output logic done,
   output logic [adavg_pkg::LANES-1:0][adavg_pkg::AVG_WIDTH-1:0] quot
);

   localparam int CW = adavg_pkg::CAP_WIDTH;
   localparam int SW = adavg_pkg::SUM_WIDTH;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [adavg_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic [CW-1:0] divisor_ff;
   logic [adavg_pkg::LANES-1:0] neg_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == adavg_pkg::STEP_WIDTH'(adavg_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         divisor_ff <= ctrl.divisor;
         neg_ff <= neg;
      end
   end

   assign done = done_ff;

   for (genvar lane = 0; lane < adavg_pkg::LANES; lane++) begin : g_lane
      logic [CW-1:0] rem_ff, rem_in;
      logic [SW-1:0] quo_ff, quo_in;
      logic [CW:0] trial;
      logic [CW:0] diff;
      logic take_bit;

      // The dividend shifts out of the top of quo_ff while quotient bits enter below.
      always_comb begin
         trial = {rem_ff, quo_ff[SW-1]};
         diff = trial - {1'b0, divisor_ff};
         take_bit = (trial >= {1'b0, divisor_ff});
         rem_in = rem_ff;
         quo_in = quo_ff;
         if (ctrl.start) begin
            rem_in = '0;
            quo_in = mag[lane];
         end else if (busy_ff) begin
            rem_in = take_bit ? diff[CW-1:0] : trial[CW-1:0];
            quo_in = {quo_ff[SW-2:0], take_bit};
         end
      end

      always_ff @(posedge clock) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end

      assign quot[lane] = neg_ff[lane] ? (16'd0 - quo_ff[adavg_pkg::AVG_WIDTH-1:0])
                                       : quo_ff[adavg_pkg::AVG_WIDTH-1:0];
   end

endmodule

FILE: rtl/adavg_back.sv
// Back end: running sums, sample count, stall watchdog, tick sequencing and the
// result register. Depends on adavg_pkg and adavg_divider.
`timescale 1ns / 1ps

module adavg_back (
   input  logic clock,
   input  logic reset,
   input  logic [adavg_pkg::CAP_WIDTH-1:0] divisor_cap,
   input  logic head_valid,
   input  adavg_pkg::item_type head_item,
   output logic head_take,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic signed [adavg_pkg::AVG_WIDTH-1:0] rsp_avg_x,
   output logic signed [adavg_pkg::AVG_WIDTH-1:0] rsp_avg_y,
   output logic signed [adavg_pkg::AVG_WIDTH-1:0] rsp_avg_z,
   output logic [adavg_pkg::CAP_WIDTH-1:0] rsp_used_count,
   output logic rsp_retrigger
);

   localparam int SW = adavg_pkg::SUM_WIDTH;
   localparam int CW = adavg_pkg::CAP_WIDTH;

   adavg_pkg::state_type state_ff, state_in;
   logic [SW-1:0] sum_x_ff, sum_x_in;
   logic [SW-1:0] sum_y_ff, sum_y_in;
   logic [SW-1:0] sum_z_ff, sum_z_in;
   logic [adavg_pkg::COUNT_WIDTH-1:0] total_ff, total_in;
   logic stall_ff, stall_in;
   logic [CW-1:0] used_ff, used_in;
   logic retrig_ff, retrig_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [adavg_pkg::AVG_WIDTH-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [CW-1:0] out_used_ff;
   logic out_retrig_ff;

   logic take_item;
   logic start_tick;
   logic load_rsp;
   logic div_done;
   adavg_pkg::div_ctrl_type div_ctrl;
   logic [adavg_pkg::LANES-1:0][SW-1:0] div_mag;
   logic [adavg_pkg::LANES-1:0] div_neg;
   logic [adavg_pkg::LANES-1:0][adavg_pkg::AVG_WIDTH-1:0] div_quot;
   logic rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_pop;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         adavg_pkg::ST_IDLE: begin
            if (head_valid && head_item.is_tick) begin
               state_in = adavg_pkg::ST_DIV;
            end
         end
         adavg_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = adavg_pkg::ST_DONE;
            end
         end
         adavg_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = adavg_pkg::ST_IDLE;
            end
         end
         default: state_in = adavg_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      take_item = 1'b0;
      start_tick = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         adavg_pkg::ST_IDLE: begin
            take_item = head_valid;
            start_tick = head_valid && head_item.is_tick;
         end
         adavg_pkg::ST_DONE: load_rsp = rsp_free;
         default: ;
      endcase
   end

   assign head_take = take_item;

   always_comb begin
      div_ctrl.start = start_tick;
      div_ctrl.divisor = used_in;
      div_mag[0] = sum_x_ff[SW-1] ? (32'd0 - sum_x_ff) : sum_x_ff;
      div_mag[1] = sum_y_ff[SW-1] ? (32'd0 - sum_y_ff) : sum_y_ff;
      div_mag[2] = sum_z_ff[SW-1] ? (32'd0 - sum_z_ff) : sum_z_ff;
      div_neg = {sum_z_ff[SW-1], sum_y_ff[SW-1], sum_x_ff[SW-1]};
   end

   always_comb begin
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      sum_z_in = sum_z_ff;
      total_in = total_ff;
      stall_in = stall_ff;
      retrig_in = retrig_ff;
      used_in = used_ff;
      if (total_ff > {8'd0, divisor_cap}) begin
         used_in = divisor_cap;
      end else begin
         used_in = total_ff[CW-1:0];
      end
      if (take_item && !head_item.is_tick) begin
         sum_x_in = sum_x_ff + adavg_pkg::widen12(head_item.val_x);
         sum_y_in = sum_y_ff + adavg_pkg::widen12(head_item.val_y);
         sum_z_in = sum_z_ff + adavg_pkg::widen12(head_item.val_z);
         if (total_ff != adavg_pkg::COUNT_MAX) begin
            total_in = total_ff + 16'd1;
         end
         stall_in = 1'b0;
      end else if (start_tick) begin
         sum_x_in = '0;
         sum_y_in = '0;
         sum_z_in = '0;
         total_in = '0;
         // A pin still high on a second tick with no sample between asks for a restart.
         retrig_in = head_item.pin && stall_ff;
         stall_in = head_item.pin;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adavg_pkg::ST_IDLE;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
         total_ff <= '0;
         stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         sum_z_ff <= sum_z_in;
         total_ff <= total_in;
         stall_ff <= stall_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start_tick) begin
         used_ff <= used_in;
         retrig_ff <= retrig_in;
      end
      if (load_rsp) begin
         out_x_ff <= (used_ff == '0) ? '0 : div_quot[0];
         out_y_ff <= (used_ff == '0) ? '0 : div_quot[1];
         out_z_ff <= (used_ff == '0) ? '0 : div_quot[2];
         out_used_ff <= used_ff;
         out_retrig_ff <= retrig_ff;
      end
   end

   adavg_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .mag   (div_mag),
      .neg   (div_neg),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_avg_x = out_x_ff;
   assign rsp_avg_y = out_y_ff;
   assign rsp_avg_z = out_z_ff;
   assign rsp_used_count = out_used_ff;
   assign rsp_retrigger = out_retrig_ff;

endmodule
